[rtl/core/mrt_pkg.sv]
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the message reassembly table.
// ----------------------------------------------------------------------------
package mrt_pkg;

	localparam int DEF_SLOTS         = 4;
	localparam int DEF_CHUNK_BYTES   = 24;
	localparam int DEF_MAX_MSG_BYTES = 1024;

	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	localparam int ID_W   = 8;
	localparam int FROM_W = 16;
	localparam int LEN_W  = 11;
	localparam int SEQ_W  = 6;
	localparam int POS_W  = 5;
	localparam int BYTE_W = 8;
	localparam int BIDX_W = 10;
	localparam int OFF_W  = 12;
	localparam int TICK_W = 32;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 48;

	typedef enum logic [2:0] {
		OP_HEAD    = 3'd0,
		OP_DATA    = 3'd1,
		OP_TAIL    = 3'd2,
		OP_TICK    = 3'd3,
		OP_READ    = 3'd4,
		OP_RELEASE = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_FREE  = 3'd1,
		ST_NO_ID    = 3'd2,
		ST_NO_DONE  = 3'd3,
		ST_BAD_IDX  = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [ID_W-1:0]   id;
		logic [FROM_W-1:0] from;
		logic [LEN_W-1:0]  len;
		logic [OFF_W-1:0]  off;
		logic              pos_ok;
		logic [BYTE_W-1:0] dbyte;
		logic [BIDX_W-1:0] bidx;
	} entry_t;

endpackage

[rtl/core/mrt_front.sv]
// ----------------------------------------------------------------------------
// mrt_front
// Accepts input transactions, unpacks them and precomputes the payload
// offset, position check and saturated length for the back end.
// ----------------------------------------------------------------------------
module mrt_front #(
	parameter int CHUNK_BYTES   = mrt_pkg::DEF_CHUNK_BYTES,
	parameter int MAX_MSG_BYTES = mrt_pkg::DEF_MAX_MSG_BYTES
) (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mrt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic [2:0]                     s_axis_tuser,
	input  logic                           q_full,
	output logic                           q_push,
	output mrt_pkg::entry_t                q_entry
);
	import mrt_pkg::*;

	logic [SEQ_W-1:0] seq;
	logic [POS_W-1:0] pos;
	logic [LEN_W-1:0] len_in;

	assign seq    = s_axis_tdata[40:35];
	assign pos    = s_axis_tdata[45:41];
	assign len_in = s_axis_tdata[34:24];

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_entry.op     = s_axis_tuser;
		q_entry.id     = s_axis_tdata[7:0];
		q_entry.from   = s_axis_tdata[23:8];
		q_entry.dbyte  = s_axis_tdata[53:46];
		q_entry.bidx   = s_axis_tdata[63:54];
		q_entry.off    = OFF_W'(seq) * OFF_W'(CHUNK_BYTES) + OFF_W'(pos);
		q_entry.pos_ok = 32'(pos) < 32'(CHUNK_BYTES);
		if (32'(len_in) > 32'(MAX_MSG_BYTES)) begin
			q_entry.len = LEN_W'(MAX_MSG_BYTES);
		end else begin
			q_entry.len = len_in;
		end
	end

endmodule

[rtl/core/mrt_fifo.sv]
// ----------------------------------------------------------------------------
// mrt_fifo
// Two-entry queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
module mrt_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mrt_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output mrt_pkg::entry_t rd_entry
);
	import mrt_pkg::*;

	entry_t     mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rd_entry  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/core/mrt_engine.sv]
// ----------------------------------------------------------------------------
// mrt_engine
// Slot table, payload memory and result register. Executes one queued
// transaction at a time: update and memory access, then result.
// ----------------------------------------------------------------------------
module mrt_engine #(
	parameter int SLOTS         = mrt_pkg::DEF_SLOTS,
	parameter int MAX_MSG_BYTES = mrt_pkg::DEF_MAX_MSG_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          q_not_empty,
	input  mrt_pkg::entry_t               q_entry,
	output logic                          q_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mrt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic [2:0]                    m_axis_tuser
);
	import mrt_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int DEPTH = SLOTS * MAX_MSG_BYTES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		E_EXEC = 2'b01,
		E_FIN  = 2'b10
	} est_t;

	est_t              state_q;
	logic [TICK_W-1:0] timeout_q;
	logic [TICK_W-1:0] now_q;
	logic [SLOTS-1:0]  used_q;
	logic [SLOTS-1:0]  done_q;
	logic [ID_W-1:0]   id_q     [SLOTS];
	logic [FROM_W-1:0] sender_q [SLOTS];
	logic [LEN_W-1:0]  len_q    [SLOTS];
	logic [TICK_W-1:0] stamp_q  [SLOTS];
	logic [BYTE_W-1:0] mem_q    [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	status_t           res_status_q;
	logic [FROM_W-1:0] res_from_q;
	logic [LEN_W-1:0]  res_len_q;
	logic [CW-1:0]     res_evict_q;
	logic              res_rd_ok_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic              free_hit, id_hit, done_hit;
	logic [SW-1:0]     free_idx, id_idx, done_idx;
	logic [TICK_W-1:0] now_next;
	logic [SLOTS-1:0]  evict_vec;
	logic [CW-1:0]     evict_cnt;
	logic [CW-1:0]     free_cnt;
	logic              any_done;
	logic              exec;
	logic              fin;
	logic [AW-1:0]     base;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic              off_ok;
	logic              bidx_ok;

	assign now_next = now_q + 1'b1;
	assign exec     = (state_q == E_EXEC) && q_not_empty;
	assign fin      = (state_q == E_FIN) && (!out_valid_q || m_axis_tready);
	assign q_pop    = fin;

	always_comb begin
		free_hit  = 1'b0;
		id_hit    = 1'b0;
		done_hit  = 1'b0;
		free_idx  = '0;
		id_idx    = '0;
		done_idx  = '0;
		evict_cnt = '0;
		free_cnt  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_idx = SW'(i);
			end
			if (used_q[i] && id_q[i] == q_entry.id) begin
				id_hit = 1'b1;
				id_idx = SW'(i);
			end
			if (used_q[i] && done_q[i]) begin
				done_hit = 1'b1;
				done_idx = SW'(i);
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			evict_vec[i] = used_q[i] && !done_q[i] &&
				((now_next - stamp_q[i]) > timeout_q);
			evict_cnt = evict_cnt + CW'(evict_vec[i]);
			free_cnt  = free_cnt + CW'(!used_q[i]);
		end
	end

	assign any_done = |(used_q & done_q);
	assign off_ok   = q_entry.pos_ok && (q_entry.off < OFF_W'(len_q[id_idx]));
	assign bidx_ok  = LEN_W'(q_entry.bidx) < len_q[done_idx];
	assign base     = AW'(q_entry.op == OP_DATA ? id_idx : done_idx)
		* AW'(MAX_MSG_BYTES);
	assign wr_addr  = base + AW'(q_entry.off);
	assign rd_addr  = base + AW'(q_entry.bidx);
	assign wr_en    = exec && q_entry.op == OP_DATA && id_hit && off_ok;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= q_entry.dbyte;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (exec && q_entry.op == OP_HEAD && free_hit) begin
			id_q[free_idx]     <= q_entry.id;
			sender_q[free_idx] <= q_entry.from;
			len_q[free_idx]    <= q_entry.len;
			stamp_q[free_idx]  <= now_q;
		end
		if (exec) begin
			res_status_q <= ST_OK;
			res_from_q   <= '0;
			res_len_q    <= '0;
			res_evict_q  <= '0;
			res_rd_ok_q  <= 1'b0;
			case (q_entry.op)
				OP_HEAD: begin
					if (!free_hit) begin
						res_status_q <= ST_NO_FREE;
					end
				end
				OP_DATA: begin
					if (!id_hit) begin
						res_status_q <= ST_NO_ID;
					end else if (!off_ok) begin
						res_status_q <= ST_BAD_IDX;
					end
				end
				OP_TAIL: begin
					if (!id_hit) begin
						res_status_q <= ST_NO_ID;
					end
				end
				OP_TICK: begin
					res_evict_q <= evict_cnt;
				end
				OP_READ, OP_RELEASE: begin
					if (!done_hit) begin
						res_status_q <= ST_NO_DONE;
					end else begin
						res_from_q <= sender_q[done_idx];
						res_len_q  <= len_q[done_idx];
						if (q_entry.op == OP_READ) begin
							if (bidx_ok) begin
								res_rd_ok_q <= 1'b1;
							end else begin
								res_status_q <= ST_BAD_IDX;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_EXEC;
			timeout_q <= TIMEOUT_RST;
			now_q     <= '0;
			used_q    <= '0;
			done_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			unique case (state_q)
				E_EXEC: begin
					if (exec) begin
						state_q <= E_FIN;
						case (q_entry.op)
							OP_HEAD: begin
								if (free_hit) begin
									used_q[free_idx] <= 1'b1;
									done_q[free_idx] <= 1'b0;
								end
							end
							OP_TAIL: begin
								if (id_hit) begin
									done_q[id_idx] <= 1'b1;
								end
							end
							OP_TICK: begin
								now_q  <= now_next;
								used_q <= used_q & ~evict_vec;
							end
							OP_RELEASE: begin
								if (done_hit) begin
									used_q[done_idx] <= 1'b0;
									done_q[done_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				E_FIN: begin
					if (fin) begin
						state_q <= E_EXEC;
					end
				end
				default: begin
					state_q <= E_EXEC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_status_q <= res_status_q;
			out_data_q   <= {6'd0, 3'(res_evict_q), 3'(free_cnt), any_done,
				res_len_q, res_from_q, res_rd_ok_q ? rdata_q : 8'd0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	a_done_used: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q & ~used_q) == '0)
		else $error("complete flag on unused slot");

	a_exec_fin: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> state_q == E_FIN)
		else $error("execute not followed by finish");

	a_no_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_NO_DONE) |->
		(out_data_q[34:0] == '0))
		else $error("fields not cleared when nothing complete");

	a_pop_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("pop from empty queue");

endmodule

[rtl/core/message_reassembly_table.sv]
// ----------------------------------------------------------------------------
// message_reassembly_table
// Reassembles segmented messages into a fixed set of slots with timeout.
// ----------------------------------------------------------------------------
// Each transaction produces exactly one result transaction. The front end
// takes a transaction whenever its two-entry queue has room; the slot engine
// handles one queued transaction at a time (slot update and payload memory
// access, then result), and the result step waits while the output register
// still holds an unaccepted result. The payload memory read is registered
// and feeds the result register. No clearing pass is needed after reset.
// Write timeout_ticks only while no transaction is in flight.
module message_reassembly_table
	import mrt_pkg::*;
#(
	parameter int SLOTS         = DEF_SLOTS,
	parameter int CHUNK_BYTES   = DEF_CHUNK_BYTES,
	parameter int MAX_MSG_BYTES = DEF_MAX_MSG_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// msg id, sender, length, chunk seq, chunk pos, data byte, byte index
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [2:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// rd_byte, rd_from, rd_length, any_complete, free_slots, evicted, zero pad
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	// status
	output logic [2:0]            m_axis_tuser
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_not_empty;
	entry_t q_wr;
	entry_t q_rd;

	mrt_front #(
		.CHUNK_BYTES   (CHUNK_BYTES),
		.MAX_MSG_BYTES (MAX_MSG_BYTES)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_wr)
	);

	mrt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_entry  (q_rd)
	);

	mrt_engine #(
		.SLOTS         (SLOTS),
		.MAX_MSG_BYTES (MAX_MSG_BYTES)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_not_empty   (q_not_empty),
		.q_entry       (q_rd),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

[test/message_reassembly_table_test.sv]
// ----------------------------------------------------------------------------
// message_reassembly_table_test
// Self-checking bench: drives head/data/tail/tick/read/release transactions,
// predicts every result in a scoreboard and compares it field by field, over
// several timeout settings with random idling on both stream sides.
// ----------------------------------------------------------------------------
module message_reassembly_table_test;
	import mrt_pkg::*;

	localparam int NSLOT = DEF_SLOTS;
	localparam int CHUNK = DEF_CHUNK_BYTES;
	localparam int MAXB  = DEF_MAX_MSG_BYTES;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  id;
		logic [15:0] from;
		logic [10:0] len;
		logic [5:0]  seq;
		logic [4:0]  pos;
		logic [7:0]  dbyte;
		logic [9:0]  bidx;
	} msg_item_t;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  rbyte;
		logic [15:0] rfrom;
		logic [10:0] rlen;
		logic        any;
		logic [2:0]  free;
		logic [2:0]  evict;
	} slot_result_t;

	class reasm_scoreboard;
		bit          used[NSLOT];
		bit          done[NSLOT];
		bit [7:0]    sid[NSLOT];
		bit [15:0]   sender[NSLOT];
		bit [10:0]   slen[NSLOT];
		bit [31:0]   stamp[NSLOT];
		bit [7:0]    mem[NSLOT][MAXB];
		bit          written[NSLOT][MAXB];
		bit [31:0]   now_ticks;
		bit [31:0]   timeout;
		slot_result_t expected_q[$];
		int          errors;

		function new();
			timeout = TIMEOUT_RST;
		endfunction

		function int find_id(bit [7:0] k);
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && sid[i] == k) return i;
			return -1;
		endfunction

		function int find_done();
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && done[i]) return i;
			return -1;
		endfunction

		function void note_input(msg_item_t it);
			slot_result_t r;
			int s;
			int off;
			r = '{default: 0};
			case (it.op)
				OP_HEAD: begin
					s = -1;
					for (int i = NSLOT - 1; i >= 0; i--)
						if (!used[i]) s = i;
					if (s < 0) r.status = ST_NO_FREE;
					else begin
						used[s] = 1;
						done[s] = 0;
						sid[s] = it.id;
						sender[s] = it.from;
						slen[s] = (it.len > MAXB) ? 11'(MAXB) : it.len;
						stamp[s] = now_ticks;
						for (int j = 0; j < MAXB; j++) written[s][j] = 0;
					end
				end
				OP_DATA: begin
					s = find_id(it.id);
					off = int'(it.seq) * CHUNK + int'(it.pos);
					if (s < 0) r.status = ST_NO_ID;
					else if (it.pos >= CHUNK || off >= slen[s]) r.status = ST_BAD_IDX;
					else begin
						mem[s][off] = it.dbyte;
						written[s][off] = 1;
					end
				end
				OP_TAIL: begin
					s = find_id(it.id);
					if (s < 0) r.status = ST_NO_ID;
					else done[s] = 1;
				end
				OP_TICK: begin
					now_ticks++;
					for (int i = 0; i < NSLOT; i++)
						if (used[i] && !done[i] && (now_ticks - stamp[i]) > timeout) begin
							used[i] = 0;
							r.evict++;
						end
				end
				OP_READ, OP_RELEASE: begin
					s = find_done();
					if (s < 0) r.status = ST_NO_DONE;
					else begin
						r.rfrom = sender[s];
						r.rlen = slen[s];
						if (it.op == OP_READ) begin
							if (it.bidx >= slen[s]) r.status = ST_BAD_IDX;
							else r.rbyte = mem[s][it.bidx];
						end else begin
							used[s] = 0;
							done[s] = 0;
						end
					end
				end
				default: ;
			endcase
			r.any = (find_done() >= 0);
			for (int i = 0; i < NSLOT; i++)
				if (!used[i]) r.free++;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [47:0] d);
			slot_result_t e;
			slot_result_t a;
			a.status = st;
			a.rbyte = d[7:0];
			a.rfrom = d[23:8];
			a.rlen = d[34:24];
			a.any = d[35];
			a.free = d[38:36];
			a.evict = d[41:39];
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction: %p", a);
				return;
			end
			e = expected_q.pop_front();
			if (a != e) begin
				errors++;
				if (errors <= 10) $display("result mismatch: expected %p actual %p", e, a);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	reasm_scoreboard sb = new();
	bit quiet = 0;
	int ready_hold = 0;

	message_reassembly_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			m_axis_tready <= arst_n;
		end else if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready <= 0;
		end else if ($urandom_range(0, 9) == 0) begin
			ready_hold = $urandom_range(1, 10) - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	// keep reads off payload bytes that no data transaction wrote
	function automatic void guard_read(ref msg_item_t it);
		int s;
		int l;
		if (it.op != OP_READ) return;
		s = sb.find_done();
		if (s < 0) return;
		l = sb.slen[s];
		if (it.bidx >= l || sb.written[s][it.bidx]) return;
		for (int j = 0; j < l; j++)
			if (sb.written[s][j]) begin
				it.bidx = 10'(j);
				return;
			end
		if (l < MAXB) it.bidx = 10'($urandom_range(l, MAXB - 1));
		else it.op = OP_TICK;
	endfunction

	task automatic send_item(msg_item_t it);
		int gap;
		guard_read(it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {it.bidx, it.dbyte, it.pos, it.seq, it.len, it.from, it.id};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	task automatic send_op(logic [2:0] op, logic [7:0] id, logic [15:0] from, logic [10:0] len,
			logic [5:0] seq, logic [4:0] pos, logic [7:0] dbyte, logic [9:0] bidx);
		msg_item_t it;
		it = '{op, id, from, len, seq, pos, dbyte, bidx};
		send_item(it);
	endtask

	task automatic drain_and_write(logic [31:0] value);
		s_axis_tvalid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
		sb.timeout = value;
	endtask

	task automatic random_item();
		msg_item_t it;
		int open_s;
		int k;
		int off;
		it.op = 3'($urandom);
		it.id = 8'($urandom);
		it.from = 16'($urandom);
		it.len = 11'($urandom);
		it.seq = 6'($urandom);
		it.pos = 5'($urandom);
		it.dbyte = 8'($urandom);
		it.bidx = 10'($urandom);
		open_s = -1;
		k = $urandom_range(0, NSLOT - 1);
		for (int i = 0; i < NSLOT; i++)
			if (sb.used[(k + i) % NSLOT] && !sb.done[(k + i) % NSLOT] && open_s < 0)
				open_s = (k + i) % NSLOT;
		k = $urandom_range(0, 99);
		if (k < 14) begin
			it.op = OP_HEAD;
			if ($urandom_range(0, 1)) it.id = 8'($urandom_range(0, 7));
			if ($urandom_range(0, 9) != 0) it.len = 11'($urandom_range(1, 60));
		end else if (k < 56) begin
			it.op = OP_DATA;
			if (open_s >= 0 && $urandom_range(0, 9) != 0 && sb.slen[open_s] != 0) begin
				it.id = sb.sid[open_s];
				off = $urandom_range(0, sb.slen[open_s] - 1);
				it.seq = 6'(off / CHUNK);
				it.pos = 5'(off % CHUNK);
			end
		end else if (k < 66) begin
			it.op = OP_TAIL;
			if (open_s >= 0 && $urandom_range(0, 7) != 0) it.id = sb.sid[open_s];
		end else if (k < 76) begin
			it.op = OP_TICK;
		end else if (k < 89) begin
			it.op = OP_READ;
			if ($urandom_range(0, 1)) it.bidx = 10'($urandom_range(0, 63));
		end else if (k < 97) begin
			it.op = OP_RELEASE;
		end
		send_item(it);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_op(OP_HEAD, 8'hFF, 16'hFFFF, 11'h7FF, 0, 0, 0, 0);
		send_op(OP_HEAD, 8'h00, 16'h0000, 11'd0, 0, 0, 0, 0);
		send_op(OP_DATA, 8'hFF, 0, 0, 6'd63, 5'd31, 8'h55, 0);
		send_op(OP_DATA, 8'hFF, 0, 0, 6'd0, 5'd0, 8'hFF, 0);
		send_op(OP_DATA, 8'hFF, 0, 0, 6'd42, 5'd15, 8'hAA, 0);
		send_op(OP_DATA, 8'hFF, 0, 0, 6'd1, 5'd24, 8'h11, 0);
		send_op(OP_DATA, 8'h00, 0, 0, 6'd0, 5'd0, 8'h22, 0);
		send_op(OP_DATA, 8'h07, 0, 0, 6'd0, 5'd0, 8'h33, 0);
		send_op(OP_TAIL, 8'h07, 0, 0, 0, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0);
		send_op(OP_TAIL, 8'hFF, 0, 0, 0, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
		send_op(OP_HEAD, 8'h00, 16'h1234, 11'd1024, 0, 0, 0, 0);
		send_op(OP_HEAD, 8'h09, 16'h8001, 11'd1, 0, 0, 0, 0);
		send_op(OP_HEAD, 8'h0A, 16'h7FFE, 11'd5, 0, 0, 0, 0);
		send_op(OP_TAIL, 8'h00, 0, 0, 0, 0, 0, 0);
		send_op(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
		send_op(OP_SPARE_A, 8'hFF, 16'hFFFF, 11'h7FF, 6'h3F, 5'h1F, 8'hFF, 10'h3FF);
		send_op(OP_SPARE_B, 0, 0, 0, 0, 0, 0, 0);
		send_op(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0);
		send_op(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 0, 10'd3);
		send_op(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0);

		drain_and_write(32'd0);
		repeat (150) random_item();
		drain_and_write(32'd3);
		repeat (300) random_item();
		drain_and_write(32'hFFFFFFFF);
		repeat (200) random_item();
		drain_and_write(32'd20);
		repeat (250) random_item();
		drain_and_write(TIMEOUT_RST);
		repeat (50) random_item();
		quiet = 1;
		repeat (150) random_item();
		s_axis_tvalid <= 0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("message_reassembly_table: match");
		else
			$display("message_reassembly_table: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("message_reassembly_table: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/core/mrt_pkg.sv
rtl/core/mrt_front.sv
rtl/core/mrt_fifo.sv
rtl/core/mrt_engine.sv
rtl/core/message_reassembly_table.sv
test/message_reassembly_table_test.sv
